@@ hw/rtl/sccb_pkg.sv @@
// sccb_pkg: shared types, codes and constants of the camera control bus master
package sccb_pkg;

    localparam int unsigned ADDR_W = 7;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIT_COUNT_W = 4;

    localparam logic [ADDR_W-1:0] DEVICE_ADDRESS_RESET = 7'd48;
    localparam logic [BIT_COUNT_W-1:0] LAST_HALF_BIT = 4'd15;

    // transaction kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // which byte of the transaction is on the bus
    typedef enum logic [1:0] {
        BYTE_ADDR = 2'd0,
        BYTE_REG  = 2'd1,
        BYTE_DATA = 2'd2,
        BYTE_DONE = 2'd3
    } byte_pos_t;

    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_START    = 7'b0000010,
        PH_SEND     = 7'b0000100,
        PH_ACK      = 7'b0001000,
        PH_STOP     = 7'b0010000,
        PH_RECV     = 7'b0100000,
        PH_RECV_END = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic              request;
        logic              command;
        logic [BYTE_W-1:0] register_index;
        logic [BYTE_W-1:0] write_value;
        logic              sda_sample;
    } sccb_in_t;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic [BYTE_W-1:0] read_byte;
        logic              read_done;
    } sccb_out_t;

endpackage

@@ hw/rtl/sccb_register_master.sv @@
// sccb_register_master: camera control bus register master, top level
//
// One request on the s_ channel is one bus timing tick (nominally 10 us). A tick
// whose request bit is set starts a register write or read if the master is idle,
// and is ignored otherwise. Every tick produces exactly one request on the m_
// channel carrying the open-drain scl and sda levels for that tick (1 released,
// 0 pulled low), the busy flag, the receive shift register and a read-done pulse.
// A write transaction (start, address, register, data, stop) spans 59 ticks; a
// read (address and register, stop, restart with address|1, eight data bits,
// nack, stop) spans 84 ticks. The acknowledge bits are not checked. Throughput is
// one tick per clock while the receiver keeps m_ready high: a tick is held in the
// input register, the sequencer steps on it as it moves into the output register,
// and both stages hold under backpressure.
// device_address is written through the cfg_ port, which is always ready; write
// it only while no ticks are in flight. The read address is taken from it when
// the restart begins.
module sccb_register_master (
    input  logic                        aclk,
    input  logic                        aresetn,

    // tick input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  sccb_pkg::sccb_in_t          s_data,

    // per-tick line levels and status
    output logic                        m_valid,
    input  logic                        m_ready,
    output sccb_pkg::sccb_out_t         m_data,

    // device address register
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sccb_pkg::ADDR_W-1:0] cfg_data
);
    import sccb_pkg::*;

    // input stage
    logic      in_valid_reg, in_valid_next;
    sccb_in_t  in_data_reg;

    // output stage
    logic      out_valid_reg, out_valid_next;
    sccb_out_t out_data_reg;

    // configuration
    logic [ADDR_W-1:0] dev_addr_reg, dev_addr_next;

    logic      advance;
    sccb_out_t step_result;

    // a held tick moves on whenever the output register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next  = s_ready ? s_valid : in_valid_reg;
        out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_ready);
        dev_addr_next  = (cfg_valid && cfg_ready) ? cfg_data : dev_addr_reg;
    end

    sccb_sequencer u_sequencer (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .device_address (dev_addr_reg),
        .item           (in_data_reg),
        .result         (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            dev_addr_reg  <= DEVICE_ADDRESS_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            dev_addr_reg  <= dev_addr_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

@@ hw/rtl/sccb_sequencer.sv @@
// sccb_sequencer: bus sequencer state and the per-tick pin step logic
module sccb_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  logic [sccb_pkg::ADDR_W-1:0]         device_address,
    input  sccb_pkg::sccb_in_t                  item,
    output sccb_pkg::sccb_out_t                 result
);
    import sccb_pkg::*;

    phase_t                 phase_reg, phase_next;
    logic [BIT_COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    byte_pos_t              byte_pos_reg, byte_pos_next;
    logic                   cmd_reg, cmd_next;
    logic [BYTE_W-1:0]      reg_index_reg, reg_index_next;
    logic [BYTE_W-1:0]      value_reg, value_next;
    logic [BYTE_W-1:0]      assembled_reg, assembled_next;

    logic                   take_req;
    phase_t                 phase_cur;
    logic [BIT_COUNT_W-1:0] bc;
    logic [BIT_COUNT_W-1:0] bc_inc;
    logic                   scl, sda, busy, done;

    always_comb begin
        take_req = (phase_reg == PH_IDLE) && item.request;

        // a request taken on an idle tick already drives the first start tick
        phase_cur      = take_req ? PH_START : phase_reg;
        bc             = take_req ? '0 : bit_count_reg;
        shift_next     = take_req ? {device_address, 1'b0} : shift_reg;
        byte_pos_next  = take_req ? BYTE_ADDR : byte_pos_reg;
        cmd_next       = take_req ? item.command : cmd_reg;
        reg_index_next = take_req ? item.register_index : reg_index_reg;
        value_next     = take_req ? item.write_value : value_reg;
        assembled_next = assembled_reg;

        bc_inc         = bc + 1'b1;
        phase_next     = phase_cur;
        bit_count_next = bc_inc;

        scl  = 1'b1;
        sda  = 1'b1;
        busy = 1'b1;
        done = 1'b0;

        unique case (phase_cur)
            PH_IDLE: begin
                busy           = 1'b0;
                bit_count_next = bc;
            end
            PH_START: begin
                sda = (bc == '0);
                if (bc != '0) begin
                    phase_next     = PH_SEND;
                    bit_count_next = '0;
                end
            end
            PH_SEND: begin
                scl = bc[0];
                sda = shift_next[BYTE_W-1];
                if (bc[0]) begin
                    shift_next = {shift_next[BYTE_W-2:0], 1'b0};
                end
                if (bc == LAST_HALF_BIT) begin
                    phase_next     = PH_ACK;
                    bit_count_next = '0;
                end
            end
            PH_ACK: begin
                scl = bc[0];
                if (bc != '0) begin
                    bit_count_next = '0;
                    priority if (byte_pos_next == BYTE_ADDR) begin
                        byte_pos_next = BYTE_REG;
                        shift_next    = reg_index_next;
                        phase_next    = PH_SEND;
                    end else if (cmd_next == CMD_WRITE && byte_pos_next == BYTE_REG) begin
                        byte_pos_next = BYTE_DATA;
                        shift_next    = value_next;
                        phase_next    = PH_SEND;
                    end else if (cmd_next == CMD_READ && byte_pos_next == BYTE_DATA) begin
                        phase_next = PH_RECV;
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
            end
            PH_STOP: begin
                scl = (bc != '0);
                sda = (bc >= 4'd2);
                if (bc >= 4'd2) begin
                    bit_count_next = '0;
                    // after the register phase of a read, restart with address|1
                    if (cmd_next == CMD_READ && byte_pos_next == BYTE_REG) begin
                        byte_pos_next = BYTE_DATA;
                        shift_next    = {device_address, 1'b1};
                        phase_next    = PH_START;
                    end else begin
                        done       = cmd_next;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_RECV: begin
                scl = bc[0];
                if (bc[0]) begin
                    assembled_next = {assembled_reg[BYTE_W-2:0], item.sda_sample};
                end
                if (bc == LAST_HALF_BIT) begin
                    phase_next     = PH_RECV_END;
                    bit_count_next = '0;
                end
            end
            PH_RECV_END: begin
                // nack clock, then pull sda low ahead of the stop
                scl = (bc == 4'd1);
                sda = (bc < 4'd3);
                if (bc >= 4'd3) begin
                    byte_pos_next  = BYTE_DONE;
                    phase_next     = PH_STOP;
                    bit_count_next = '0;
                end
            end
            default: begin
                busy           = 1'b0;
                phase_next     = PH_IDLE;
                bit_count_next = '0;
            end
        endcase

        result.scl_level = scl;
        result.sda_level = sda;
        result.busy_res  = busy;
        result.read_byte = assembled_next;
        result.read_done = done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            byte_pos_reg  <= BYTE_ADDR;
            cmd_reg       <= CMD_WRITE;
            reg_index_reg <= '0;
            value_reg     <= '0;
            assembled_reg <= '0;
        end else if (step_en) begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            byte_pos_reg  <= byte_pos_next;
            cmd_reg       <= cmd_next;
            reg_index_reg <= reg_index_next;
            value_reg     <= value_next;
            assembled_reg <= assembled_next;
        end
    end

endmodule

@@ dv/tb.sv @@
// tb: self-checking testbench for the camera control bus register master
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sccb_pkg::*;

    localparam int WRITE_TICKS = 59;
    localparam int READ_TICKS  = 84;
    localparam int CYCLE_LIMIT = 400000;

    // predicts the line levels and status of every tick and checks them in order
    class line_level_board;
        logic [ADDR_W-1:0] dev_addr;
        phase_t            phase;
        logic [3:0]        half_bit;
        logic [7:0]        shift_byte;
        byte_pos_t         byte_pos;
        logic              cmd;
        logic [7:0]        reg_latch;
        logic [7:0]        val_latch;
        logic [7:0]        rx_byte;
        sccb_out_t         expected_levels[$];
        int                errors;
        int                checked;

        function new();
            dev_addr   = DEVICE_ADDRESS_RESET;
            phase      = PH_IDLE;
            half_bit   = '0;
            shift_byte = '0;
            byte_pos   = BYTE_ADDR;
            cmd        = CMD_WRITE;
            reg_latch  = '0;
            val_latch  = '0;
            rx_byte    = '0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void enter_phase(phase_t p);
            phase    = p;
            half_bit = '0;
        endfunction

        function int pending();
            return expected_levels.size();
        endfunction

        // one accepted tick: step the sequencer and queue the levels it drives
        function void note_tick(sccb_in_t t);
            sccb_out_t  r;
            logic [3:0] b;
            r.scl_level = 1'b1;
            r.sda_level = 1'b1;
            r.busy_res  = 1'b1;
            r.read_done = 1'b0;
            b = half_bit;
            if (phase == PH_IDLE && t.request) begin
                cmd        = t.command;
                reg_latch  = t.register_index;
                val_latch  = t.write_value;
                byte_pos   = BYTE_ADDR;
                shift_byte = {dev_addr, 1'b0};
                enter_phase(PH_START);
                b = '0;
            end
            case (phase)
                PH_IDLE: begin
                    r.busy_res = 1'b0;
                end
                PH_START: begin
                    r.sda_level = (b == 0);
                    if (b >= 1) enter_phase(PH_SEND);
                    else half_bit = b + 4'd1;
                end
                PH_SEND: begin
                    r.scl_level = b[0];
                    r.sda_level = shift_byte[7];
                    if (b[0]) shift_byte = shift_byte << 1;
                    if (b >= LAST_HALF_BIT) enter_phase(PH_ACK);
                    else half_bit = b + 4'd1;
                end
                PH_ACK: begin
                    r.scl_level = b[0];
                    if (b < 1) begin
                        half_bit = b + 4'd1;
                    end else if (byte_pos == BYTE_ADDR) begin
                        byte_pos   = BYTE_REG;
                        shift_byte = reg_latch;
                        enter_phase(PH_SEND);
                    end else if (cmd == CMD_WRITE && byte_pos == BYTE_REG) begin
                        byte_pos   = BYTE_DATA;
                        shift_byte = val_latch;
                        enter_phase(PH_SEND);
                    end else if (cmd == CMD_READ && byte_pos == BYTE_DATA) begin
                        enter_phase(PH_RECV);
                    end else begin
                        enter_phase(PH_STOP);
                    end
                end
                PH_STOP: begin
                    r.scl_level = (b != 0);
                    r.sda_level = (b >= 2);
                    if (b < 2) begin
                        half_bit = b + 4'd1;
                    end else if (cmd == CMD_READ && byte_pos == BYTE_REG) begin
                        // restart with the read address
                        byte_pos   = BYTE_DATA;
                        shift_byte = {dev_addr, 1'b1};
                        enter_phase(PH_START);
                    end else begin
                        r.read_done = cmd;
                        enter_phase(PH_IDLE);
                    end
                end
                PH_RECV: begin
                    r.scl_level = b[0];
                    if (b[0]) rx_byte = {rx_byte[6:0], t.sda_sample};
                    if (b >= LAST_HALF_BIT) enter_phase(PH_RECV_END);
                    else half_bit = b + 4'd1;
                end
                PH_RECV_END: begin
                    // nack clock, then pull sda low ahead of the stop
                    r.scl_level = (b == 1);
                    r.sda_level = !(b >= 3);
                    if (b >= 3) begin
                        byte_pos = BYTE_DONE;
                        enter_phase(PH_STOP);
                    end else begin
                        half_bit = b + 4'd1;
                    end
                end
                default: begin
                    r.busy_res = 1'b0;
                    enter_phase(PH_IDLE);
                end
            endcase
            r.read_byte = rx_byte;
            expected_levels.push_back(r);
        endfunction

        task report(string what, logic [7:0] got, logic [7:0] want);
            errors++;
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        endtask

        task check_levels(sccb_out_t got);
            sccb_out_t want;
            if (expected_levels.size() == 0) begin
                report("result with no tick waiting", '0, '0);
                return;
            end
            want = expected_levels.pop_front();
            checked++;
            if (got.scl_level !== want.scl_level)
                report("scl_level", 8'(got.scl_level), 8'(want.scl_level));
            if (got.sda_level !== want.sda_level)
                report("sda_level", 8'(got.sda_level), 8'(want.sda_level));
            if (got.busy_res !== want.busy_res)
                report("busy_res", 8'(got.busy_res), 8'(want.busy_res));
            if (got.read_byte !== want.read_byte)
                report("read_byte", got.read_byte, want.read_byte);
            if (got.read_done !== want.read_done)
                report("read_done", 8'(got.read_done), 8'(want.read_done));
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sccb_in_t          s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    sccb_out_t         m_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data = '0;

    line_level_board sb = new();

    int tick_count = 0;
    int write_count = 0;
    int read_count = 0;
    int addr_count = 1;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    sccb_register_master dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_levels(m_data);
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic sccb_in_t random_tick(logic req);
        sccb_in_t t;
        t.request        = req;
        t.command        = 1'($urandom_range(1));
        t.register_index = 8'($urandom_range(255));
        t.write_value    = 8'($urandom_range(255));
        t.sda_sample     = 1'($urandom_range(1));
        return t;
    endfunction

    // one tick request; valid stays high after acceptance for a following tick
    task automatic send_tick(sccb_in_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(t);
        tick_count++;
    endtask

    // whole transaction; busy ticks carry random fields, sda optionally forced
    task automatic run_transaction(logic c, logic [7:0] ri, logic [7:0] wv, int sda_fix);
        sccb_in_t t;
        int       len;
        t = random_tick(1'b1);
        t.command        = c;
        t.register_index = ri;
        t.write_value    = wv;
        send_tick(t);
        len = (c == CMD_READ) ? READ_TICKS : WRITE_TICKS;
        for (int i = 1; i < len; i++) begin
            t = random_tick(1'($urandom_range(1)));
            if (sda_fix >= 0) t.sda_sample = sda_fix[0];
            send_tick(t);
        end
        if (c == CMD_READ) read_count++;
        else write_count++;
    endtask

    // wait for every expected result, then let the pipeline settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_address(logic [ADDR_W-1:0] a);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.dev_addr = a;
        addr_count++;
    endtask

    initial begin
        int phase_end;
        logic [ADDR_W-1:0] addr;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset address, byte extremes, read of all ones and all zeros
        send_tick(random_tick(1'b0));
        run_transaction(CMD_WRITE, 8'h00, 8'hff, -1);
        run_transaction(CMD_WRITE, 8'hff, 8'h00, -1);
        run_transaction(CMD_READ, 8'hff, 8'h00, 1);
        send_tick(random_tick(1'b0));
        run_transaction(CMD_READ, 8'h00, 8'hff, 0);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (ph > 0) begin
                drain();
                case (ph)
                    1: addr = '0;
                    2: addr = '1;
                    4: addr = DEVICE_ADDRESS_RESET;
                    default: addr = 7'($urandom_range(127));
                endcase
                write_address(addr);
            end
            phase_end = tick_count + 170;
            while (tick_count < phase_end) begin
                if ($urandom_range(9) == 0) begin
                    // idle noise, request low
                    repeat ($urandom_range(4, 1)) send_tick(random_tick(1'b0));
                end else begin
                    run_transaction(1'($urandom_range(1)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)), -1);
                    repeat ($urandom_range(2)) send_tick(random_tick(1'b0));
                end
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("summary: %0d ticks, %0d register writes, %0d register reads", tick_count,
                 write_count, read_count);
        $display("summary: %0d results checked over %0d device addresses, %0d mismatches",
                 sb.checked, addr_count, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
